>>> hw/rtl/slcb_pkg.sv
// shared types and constants for the status led colour blinker
// payload structs, config bundle, queue entry and back-end state codes
package slcb_pkg;

   localparam int unsigned TIMING_W   = 32;
   localparam int unsigned COLOURS_W  = 48;
   localparam int unsigned COLOUR_W   = 24;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned DIV_STEPS  = 32;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCONNECT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_GREEN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_WHITE = 3'd6;

   localparam logic [TIMING_W-1:0]  TIMING_RESET     = 32'h0050_0028;
   localparam logic [COLOURS_W-1:0] RED_GREEN_RESET  = 48'h00FF_00FF_0000;
   localparam logic [COLOURS_W-1:0] BLUE_WHITE_RESET = 48'h0000_FFFF_FFFF;

   // byte slot codes on the result channel
   localparam logic [1:0] SLOT_GREEN = 2'd0;
   localparam logic [1:0] SLOT_RED   = 2'd1;
   localparam logic [1:0] SLOT_BLUE  = 2'd2;

   typedef struct packed {
      logic frame_start;
      logic slot_disabled;
      logic overcurrent_trip;
      logic reverse_polarity;
      logic group_disconnect;
      logic calibrating;
      logic paused;
      logic watchdog_tripped;
      logic restored;
      logic charging_or_discharging;
      logic running;
      logic finished;
   } slcb_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [1:0]        colour_slot;
      logic              last_byte;
   } slcb_rsp_type;

   typedef struct packed {
      logic [TIMING_W-1:0]  trip_timing;
      logic [TIMING_W-1:0]  reverse_timing;
      logic [TIMING_W-1:0]  disconnect_timing;
      logic [TIMING_W-1:0]  calibrate_timing;
      logic [TIMING_W-1:0]  pause_timing;
      logic [COLOURS_W-1:0] red_green_colours;
      logic [COLOURS_W-1:0] blue_white_colours;
   } slcb_cfg_type;

   // one classified channel waiting for the back end
   typedef struct packed {
      logic [COLOUR_W-1:0] colour;
      logic                flash;
      logic [TIMING_W-1:0] timing;
      logic [TICK_W-1:0]   tick;
   } slcb_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } slcb_back_state_type;

endpackage

>>> hw/rtl/slcb_front.sv
// front end: accepts request words, advances the tick, picks colour and flash timing
// depends on slcb_pkg
module slcb_front import slcb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  slcb_req_type   req_data,
   input  slcb_cfg_type   cfg,
   input  logic           q_full,
   output logic           q_push,
   output slcb_entry_type q_entry
);

   logic [TICK_W-1:0]   tick_ff;
   logic [TICK_W-1:0]   tick_in;
   logic [COLOUR_W-1:0] red;
   logic [COLOUR_W-1:0] green;
   logic [COLOUR_W-1:0] blue;
   logic [COLOUR_W-1:0] white;

   assign red   = cfg.red_green_colours[COLOURS_W-1:COLOUR_W];
   assign green = cfg.red_green_colours[COLOUR_W-1:0];
   assign blue  = cfg.blue_white_colours[COLOURS_W-1:COLOUR_W];
   assign white = cfg.blue_white_colours[COLOUR_W-1:0];

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign tick_in   = tick_ff + TICK_W'(req_data.frame_start);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (q_push) begin
         tick_ff <= tick_in;
      end
   end

   // fixed priority, highest first
   always_comb begin
      q_entry.tick   = tick_in;
      q_entry.flash  = 1'b0;
      q_entry.timing = '0;
      q_entry.colour = green;
      if (req_data.slot_disabled) begin
         q_entry.colour = red;
      end else if (req_data.overcurrent_trip) begin
         q_entry.colour = red;
         q_entry.flash  = 1'b1;
         q_entry.timing = cfg.trip_timing;
      end else if (req_data.reverse_polarity) begin
         q_entry.colour = red;
         q_entry.flash  = 1'b1;
         q_entry.timing = cfg.reverse_timing;
      end else if (req_data.group_disconnect) begin
         q_entry.colour = red;
         q_entry.flash  = 1'b1;
         q_entry.timing = cfg.disconnect_timing;
      end else if (req_data.calibrating) begin
         q_entry.colour = white;
         q_entry.flash  = 1'b1;
         q_entry.timing = cfg.calibrate_timing;
      end else if (req_data.paused) begin
         q_entry.colour = (req_data.watchdog_tripped || req_data.restored) ? red : blue;
         q_entry.flash  = 1'b1;
         q_entry.timing = cfg.pause_timing;
      end else if (req_data.charging_or_discharging) begin
         q_entry.colour = req_data.running ? blue : green;
      end else if (req_data.finished) begin
         q_entry.colour = white;
      end
   end

endmodule

>>> hw/rtl/slcb_queue.sv
// two-entry queue between front and back end
// depends on slcb_pkg
module slcb_queue import slcb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  slcb_entry_type push_entry,
   input  logic           pop,
   output slcb_entry_type head,
   output logic           empty,
   output logic           full
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   slcb_entry_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> hw/rtl/slcb_modulo.sv
// iterative remainder unit: 32-bit tick modulo 16-bit period, one bit a cycle
// depends on slcb_pkg
module slcb_modulo import slcb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TICK_W-1:0] dividend,
   input  logic [HALF_W-1:0] divisor,
   output logic              done,
   output logic [HALF_W-1:0] remainder
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [TICK_W-1:0]    shift_ff;
   logic [HALF_W-1:0]    rem_ff;
   logic [HALF_W-1:0]    divisor_ff;
   logic [HALF_W:0]      trial;
   logic [HALF_W:0]      diff;
   logic [HALF_W-1:0]    rem_in;

   // partial remainder stays below the divisor, so the difference fits
   assign trial  = {rem_ff, shift_ff[TICK_W-1]};
   assign diff   = trial - {1'b0, divisor_ff};
   assign rem_in = (trial >= {1'b0, divisor_ff}) ? diff[HALF_W-1:0] : trial[HALF_W-1:0];

   assign done      = done_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff   <= dividend;
         divisor_ff <= divisor;
         rem_ff     <= '0;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[TICK_W-2:0], 1'b0};
         rem_ff   <= rem_in;
      end
   end

endmodule

>>> hw/rtl/slcb_back.sv
// back end: resolves flash phase through the remainder unit and sends g, r, b words
// depends on slcb_pkg and slcb_modulo
module slcb_back import slcb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  slcb_entry_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output slcb_rsp_type   rsp_data
);

   slcb_back_state_type state_ff, state_in;
   slcb_entry_type      entry_ff, entry_in;
   logic                lit_ff, lit_in;
   logic [1:0]          slot_ff, slot_in;
   logic                div_start;
   logic                div_done;
   logic [HALF_W-1:0]   div_rem;
   logic [HALF_W-1:0]   head_period;
   logic [BYTE_W-1:0]   byte_sel;

   assign head_period = q_head.timing[TIMING_W-1:HALF_W];

   slcb_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (q_head.tick),
      .divisor   (head_period),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lit_ff   <= lit_in;
      slot_ff  <= slot_in;
   end

   always_comb begin
      state_in  = state_ff;
      entry_in  = entry_ff;
      lit_in    = lit_ff;
      slot_in   = slot_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               entry_in = q_head;
               slot_in  = SLOT_GREEN;
               if (!q_head.flash) begin
                  lit_in   = 1'b1;
                  state_in = BK_EMIT;
               end else if (head_period == '0) begin
                  // zero period shows dark
                  lit_in   = 1'b0;
                  state_in = BK_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            if (div_done) begin
               lit_in   = (div_rem < entry_ff.timing[HALF_W-1:0]);
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (slot_ff == SLOT_BLUE) begin
                  state_in = BK_IDLE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      case (slot_ff)
         SLOT_GREEN: byte_sel = entry_ff.colour[23:16];
         SLOT_RED:   byte_sel = entry_ff.colour[15:8];
         SLOT_BLUE:  byte_sel = entry_ff.colour[7:0];
         default:    byte_sel = '0;
      endcase
   end

   assign rsp_data.data_byte   = lit_ff ? (byte_sel & BYTE_MASK) : '0;
   assign rsp_data.colour_slot = slot_ff;
   assign rsp_data.last_byte   = (slot_ff == SLOT_BLUE);

endmodule

>>> hw/rtl/status_led_colour_blinker.sv
// top level of the status led colour blinker: csr bank, front, queue and back end
// depends on slcb_pkg, slcb_front, slcb_queue, slcb_back
//
// usage
// - req channel: one word per led channel, carrying its status flags and a
//   frame_start flag that bumps the refresh tick before the channel is judged
// - rsp channel: three words per request, g then r then b, last_byte on b;
//   a dark flash phase sends zero bytes with the usual slot codes
// - csr channel: csr_ready is always high, csr_index picks the register,
//   unknown indexes are dropped; write only while the block is idle
// - flow: a request is classified and queued at acceptance; the back end pops
//   it once idle and shows the g word in the cycle after the pop for a solid
//   colour, or after the 32-step remainder unit finishes for a flash
// - the back end works on one request at a time: the bit-serial remainder
//   unit for flashes with a nonzero period, then the three output words
// - the two-entry queue lets requests keep arriving while the back end works;
//   req_stall rises only when that queue is full
// - reset: tick clears to zero, registers take their default timing and
//   colours, queue empties and no rsp word is pending
// - rsp_stall simply holds the current word; everything behind it waits
module status_led_colour_blinker import slcb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  slcb_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slcb_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOURS_W-1:0] csr_data
);

   slcb_cfg_type   cfg_ff;
   slcb_entry_type push_entry;
   slcb_entry_type q_head;
   logic           q_push;
   logic           q_pop;
   logic           q_empty;
   logic           q_full;

   // register bank, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_timing        <= TIMING_RESET;
         cfg_ff.reverse_timing     <= TIMING_RESET;
         cfg_ff.disconnect_timing  <= TIMING_RESET;
         cfg_ff.calibrate_timing   <= TIMING_RESET;
         cfg_ff.pause_timing       <= TIMING_RESET;
         cfg_ff.red_green_colours  <= RED_GREEN_RESET;
         cfg_ff.blue_white_colours <= BLUE_WHITE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIP:       cfg_ff.trip_timing        <= csr_data[TIMING_W-1:0];
            CSR_REVERSE:    cfg_ff.reverse_timing     <= csr_data[TIMING_W-1:0];
            CSR_DISCONNECT: cfg_ff.disconnect_timing  <= csr_data[TIMING_W-1:0];
            CSR_CALIBRATE:  cfg_ff.calibrate_timing   <= csr_data[TIMING_W-1:0];
            CSR_PAUSE:      cfg_ff.pause_timing       <= csr_data[TIMING_W-1:0];
            CSR_RED_GREEN:  cfg_ff.red_green_colours  <= csr_data;
            CSR_BLUE_WHITE: cfg_ff.blue_white_colours <= csr_data;
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   // front: accept, tick, priority pick
   slcb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // decoupling queue
   slcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // back: flash phase and byte sequencing
   slcb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue read while empty");

   a_bytes_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_byte) |=> rsp_valid)
      else $error("word group broken before its last byte");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_byte)
         |=> (rsp_data.colour_slot == $past(rsp_data.colour_slot) + 2'd1))
      else $error("colour slot out of order");

endmodule

>>> test/tb.sv
// testbench for status_led_colour_blinker: random and directed status words with a local
// colour and flash predictor, random idling on both channels, csr phases between bursts
// depends on slcb_pkg and the status_led_colour_blinker rtl
module tb;
   import slcb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 40;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   slcb_req_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   slcb_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOURS_W-1:0] csr_data = '0;

   // one status word waiting for the driver; drain_first holds it back until
   // every byte expected so far has come out
   typedef struct packed {
      logic         drain_first;
      slcb_req_type word;
   } pending_type;

   pending_type  pending_q[$];
   slcb_rsp_type colour_bytes_q[$];

   // local copy of the block's registers and refresh tick
   slcb_cfg_type cfg_copy;
   logic [TICK_W-1:0] tick_copy;

   int unsigned send_idle_pct = 18;
   int unsigned recv_idle_pct = 83;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   slcb_rsp_type oldest_byte;

   status_led_colour_blinker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // lit while tick mod period is below the lit count, a zero period is dark
   function automatic bit flash_on(input logic [TIMING_W-1:0] timing);
      logic [TICK_W-1:0] period;
      period = {16'h0, timing[31:16]};
      if (period == '0) return 1'b0;
      return (tick_copy % period) < {16'h0, timing[15:0]};
   endfunction

   // bump the tick if asked, pick the colour by priority and queue its g, r, b bytes
   task automatic predict_colour_bytes(input slcb_req_type w);
      logic [COLOUR_W-1:0] red, green, blue, white, colour;
      red   = cfg_copy.red_green_colours[47:24];
      green = cfg_copy.red_green_colours[23:0];
      blue  = cfg_copy.blue_white_colours[47:24];
      white = cfg_copy.blue_white_colours[23:0];
      if (w.frame_start) tick_copy = tick_copy + 1'b1;
      if (w.slot_disabled) colour = red;
      else if (w.overcurrent_trip) colour = flash_on(cfg_copy.trip_timing) ? red : '0;
      else if (w.reverse_polarity) colour = flash_on(cfg_copy.reverse_timing) ? red : '0;
      else if (w.group_disconnect) colour = flash_on(cfg_copy.disconnect_timing) ? red : '0;
      else if (w.calibrating) colour = flash_on(cfg_copy.calibrate_timing) ? white : '0;
      else if (w.paused) begin
         // watchdog or restore pause flashes red, a plain pause flashes blue
         colour = flash_on(cfg_copy.pause_timing) ?
                  ((w.watchdog_tripped || w.restored) ? red : blue) : '0;
      end
      else if (w.charging_or_discharging) colour = w.running ? blue : green;
      else if (w.finished) colour = white;
      else colour = green;
      colour_bytes_q.push_back(slcb_rsp_type'{data_byte: colour[23:16],
                                              colour_slot: SLOT_GREEN, last_byte: 1'b0});
      colour_bytes_q.push_back(slcb_rsp_type'{data_byte: colour[15:8],
                                              colour_slot: SLOT_RED, last_byte: 1'b0});
      colour_bytes_q.push_back(slcb_rsp_type'{data_byte: colour[7:0],
                                              colour_slot: SLOT_BLUE, last_byte: 1'b1});
   endtask

   // driver: present the next pending word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_colour_bytes(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 &&
                !(pending_q[0].drain_first && colour_bytes_q.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_q[0].word;
               req_valid <= 1'b1;
               void'(pending_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted byte against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (colour_bytes_q.size() == 0) begin
               $error("unexpected word: data_byte %0h colour_slot %0d last_byte %0b",
                      rsp_data.data_byte, rsp_data.colour_slot, rsp_data.last_byte);
               error_count++;
            end else begin
               oldest_byte = colour_bytes_q.pop_front();
               if (rsp_data.data_byte !== oldest_byte.data_byte) begin
                  $error("data_byte: expected %0h, actual %0h",
                         oldest_byte.data_byte, rsp_data.data_byte);
                  error_count++;
               end
               if (rsp_data.colour_slot !== oldest_byte.colour_slot) begin
                  $error("colour_slot: expected %0d, actual %0d",
                         oldest_byte.colour_slot, rsp_data.colour_slot);
                  error_count++;
               end
               if (rsp_data.last_byte !== oldest_byte.last_byte) begin
                  $error("last_byte: expected %0b, actual %0b",
                         oldest_byte.last_byte, rsp_data.last_byte);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // mirror of the csr bank; indexes past the list are dropped
   task automatic csr_copy_write(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [COLOURS_W-1:0] value);
      case (idx)
         CSR_TRIP:       cfg_copy.trip_timing = value[31:0];
         CSR_REVERSE:    cfg_copy.reverse_timing = value[31:0];
         CSR_DISCONNECT: cfg_copy.disconnect_timing = value[31:0];
         CSR_CALIBRATE:  cfg_copy.calibrate_timing = value[31:0];
         CSR_PAUSE:      cfg_copy.pause_timing = value[31:0];
         CSR_RED_GREEN:  cfg_copy.red_green_colours = value;
         CSR_BLUE_WHITE: cfg_copy.blue_white_colours = value;
         default: ;
      endcase
   endtask

   // called at a rising edge; leaves csr_valid high for a following write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COLOURS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_copy_write(idx, value);
   endtask

   // timing registers get junk in the unused upper csr bits
   task automatic program_regs(input logic [31:0] t_trip, t_rev, t_disc, t_cal, t_pause,
                               input logic [COLOURS_W-1:0] rg, bw);
      csr_write(CSR_TRIP,       {16'($urandom()), t_trip});
      csr_write(CSR_REVERSE,    {16'($urandom()), t_rev});
      csr_write(CSR_DISCONNECT, {16'($urandom()), t_disc});
      csr_write(CSR_CALIBRATE,  {16'($urandom()), t_cal});
      csr_write(CSR_PAUSE,      {16'($urandom()), t_pause});
      csr_write(CSR_RED_GREEN,  rg);
      csr_write(CSR_BLUE_WHITE, bw);
      // index beyond the bank, must change nothing
      csr_write(CSR_BLUE_WHITE + 3'd1, 48'({$urandom(), $urandom()}));
      csr_valid <= 1'b0;
   endtask

   // mostly short periods so ticks cross lit and dark phases often
   function automatic logic [31:0] rand_timing();
      logic [15:0] period, lit;
      if ($urandom_range(9) == 0) return $urandom();
      period = 16'($urandom_range(12));
      lit = 16'($urandom_range(14));
      return {period, lit};
   endfunction

   // usually pick one winning flag, clear everything above it and leave the rest random
   function automatic slcb_req_type rand_word();
      logic [11:0] bits;
      int unsigned winner;
      bits = 12'($urandom());
      if ($urandom_range(4) != 0) begin
         case ($urandom_range(8))
            0: winner = 10;
            1: winner = 9;
            2: winner = 8;
            3: winner = 7;
            4: winner = 6;
            5: winner = 5;
            6: winner = 2;
            7: winner = 0;
            default: winner = 11;
         endcase
         if (winner == 11) begin
            bits = bits & ~12'h7E5;
         end else begin
            for (int b = 10; b > int'(winner); b--) bits[b] = 1'b0;
            bits[winner] = 1'b1;
         end
      end
      return slcb_req_type'(bits);
   endfunction

   task automatic queue_word(input slcb_req_type w, input logic drain_first);
      pending_q.push_back(pending_type'{drain_first: drain_first, word: w});
   endtask

   task automatic queue_random(input int unsigned count, input int unsigned drain_at);
      for (int unsigned i = 0; i < count; i++) queue_word(rand_word(), i == drain_at);
   endtask

   // wait for all words taken and all bytes seen, then let the back end settle
   task automatic wait_drained();
      do @(negedge clock); while (pending_q.size() != 0 || req_valid ||
                                  colour_bytes_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      cfg_copy = slcb_cfg_type'{TIMING_RESET, TIMING_RESET, TIMING_RESET, TIMING_RESET,
                                TIMING_RESET, RED_GREEN_RESET, BLUE_WHITE_RESET};
      tick_copy = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset timing and colours: every priority level on its own
      @(negedge clock);
      queue_word('0, 1'b0);
      queue_word(slcb_req_type'{frame_start: 1'b1, slot_disabled: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{overcurrent_trip: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{reverse_polarity: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{group_disconnect: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{calibrating: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{paused: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{paused: 1'b1, watchdog_tripped: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{paused: 1'b1, restored: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{charging_or_discharging: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{charging_or_discharging: 1'b1, running: 1'b1,
                                default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{finished: 1'b1, default: 1'b0}, 1'b0);
      queue_word('1, 1'b0);
      queue_word(slcb_req_type'{frame_start: 1'b1, watchdog_tripped: 1'b1, restored: 1'b1,
                                running: 1'b1, default: 1'b0}, 1'b0);
      wait_drained();

      // short flashes, zero period, lit count above the period and a zero lit count
      program_regs(32'h0002_0001, 32'h0000_0005, 32'h0003_FFFF, 32'hFFFF_0000,
                   32'h0004_0002, 48'h123456_ABCDEF, 48'h0F1E2D_C3B2A1);
      @(negedge clock);
      queue_word(slcb_req_type'{frame_start: 1'b1, overcurrent_trip: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{frame_start: 1'b1, overcurrent_trip: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{overcurrent_trip: 1'b1, finished: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{reverse_polarity: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{frame_start: 1'b1, group_disconnect: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{calibrating: 1'b1, paused: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{frame_start: 1'b1, paused: 1'b1, watchdog_tripped: 1'b1,
                                default: 1'b0}, 1'b0);
      // sender holds this one until the link is empty
      queue_word(slcb_req_type'{frame_start: 1'b1, paused: 1'b1, watchdog_tripped: 1'b1,
                                default: 1'b0}, 1'b1);
      queue_word(slcb_req_type'{frame_start: 1'b1, paused: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{charging_or_discharging: 1'b1, running: 1'b1,
                                finished: 1'b1, default: 1'b0}, 1'b0);
      queue_word(slcb_req_type'{finished: 1'b1, default: 1'b0}, 1'b0);
      wait_drained();

      // random settings, idling swapped
      send_idle_pct = 83;
      recv_idle_pct = 18;
      program_regs(rand_timing(), rand_timing(), rand_timing(), rand_timing(), rand_timing(),
                   48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
      @(negedge clock);
      queue_random(35, 35);
      wait_drained();

      // extremes: full-width timings, zero period, all-ones and all-zero colours
      program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000, 32'h0001_0001,
                   32'hFFFF_FFFF, '1, '0);
      @(negedge clock);
      queue_random(25, 25);
      wait_drained();

      // no idling from here on
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(rand_timing(), rand_timing(), rand_timing(), rand_timing(), rand_timing(),
                   '0, '1);
      @(negedge clock);
      queue_random(35, 35);
      wait_drained();

      program_regs(rand_timing(), rand_timing(), rand_timing(), rand_timing(), rand_timing(),
                   48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
      @(negedge clock);
      queue_random(40, 20);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (colour_bytes_q.size() != 0) begin
         $error("%0d expected bytes never arrived", colour_bytes_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
